@@ sv/prpd_pkg.sv @@
// Shared types and constants for the pulse rate peak detector.
// Used by the controller, the datapath and the top level.
`default_nettype none

package prpd_pkg;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MID_W = 12;
	localparam int CNT_W = 16;
	localparam int RATE_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_MID_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUMERATOR = 2'd2;

	localparam logic [MID_W-1:0] MID_LEVEL_RST = 12'd2048;
	localparam logic [CNT_W-1:0] CONFIRM_COUNT_RST = 16'd40;
	localparam logic [RATE_W-1:0] RATE_NUMERATOR_RST = 16'd12000;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic start_smooth;
		logic eval;
		logic start_rate;
		logic emit;
	} prpd_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic div_done;
		logic beat;
		logic out_free;
	} prpd_sts_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SMOOTH = 5'b00010,
		ST_EVAL   = 5'b00100,
		ST_WAIT_R = 5'b01000,
		ST_EMIT   = 5'b10000
	} prpd_state_t;

endpackage

`default_nettype wire

@@ sv/prpd_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Standalone; used for the beat rate division.
`default_nettype none

module prpd_div #(
	parameter int DW = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               done,
	output logic [DW-1:0]      quotient
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] quo_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   rem_sh;
	logic          fits;

	assign rem_sh = {rem_q, quo_q[DW-1]};
	assign fits = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DW'(rem_sh - {1'b0, dvs_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[DW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

@@ sv/prpd_ctrl.sv @@
// Controller state machine for the pulse rate peak detector.
// Depends on prpd_pkg for command, status and state types.
`default_nettype none

module prpd_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                sample_valid,
	output logic                     sample_ready,
	input  wire prpd_pkg::prpd_sts_t sts,
	output prpd_pkg::prpd_cmd_t      cmd
);

	import prpd_pkg::*;

	prpd_state_t state_q;
	prpd_state_t state_nxt;

	always_comb begin
		state_nxt = state_q;
		cmd = '0;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_SMOOTH;
				end
			end
			ST_SMOOTH: begin
				cmd.start_smooth = 1'b1;
				state_nxt = ST_EVAL;
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.beat) begin
					cmd.start_rate = 1'b1;
					state_nxt = ST_WAIT_R;
				end else begin
					state_nxt = ST_IDLE;
				end
			end
			ST_WAIT_R: begin
				if (sts.div_done) begin
					state_nxt = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

@@ sv/prpd_datapath.sv @@
// Datapath: sample ring, running sum, peak tracking, config registers, output register.
// Depends on prpd_pkg and prpd_div.
`default_nettype none

module prpd_datapath #(
	parameter int FILTER_TAPS = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire prpd_pkg::prpd_cmd_t            cmd,
	output prpd_pkg::prpd_sts_t                 sts,
	input  wire logic [SAMPLE_BITS-1:0]         sample,
	input  wire logic                           cfg_we,
	input  wire logic [prpd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [prpd_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                                beat_rate_valid,
	input  wire logic                           beat_rate_ready,
	output logic [prpd_pkg::RATE_W-1:0]         beat_rate
);

	import prpd_pkg::*;

	localparam int TAP_W = $clog2(FILTER_TAPS);
	localparam int SUM_W = SAMPLE_BITS + TAP_W;
	localparam int DW = CNT_W;
	localparam int PEAK_W = (SAMPLE_BITS > MID_W) ? SAMPLE_BITS : MID_W;
	// sum / FILTER_TAPS as (sum * RCP) >> RCP_SH, exact over the whole sum range
	localparam int RCP_SH = SUM_W + TAP_W;
	localparam int RCP_W = SUM_W + 1;
	localparam int PROD_W = SUM_W + RCP_W;
	localparam logic [RCP_W-1:0] RCP = RCP_W'(((64'd1 << RCP_SH) + 64'(FILTER_TAPS)
		- 64'd1) / 64'(FILTER_TAPS));

	logic [SAMPLE_BITS-1:0] ring_q [FILTER_TAPS];
	logic [TAP_W-1:0]       ptr_q;
	logic [SUM_W-1:0]       sum_q;
	logic [CNT_W-1:0]       elapsed_q;
	logic [PEAK_W-1:0]      peak_q;
	logic [CNT_W-1:0]       pos_q;
	logic [CNT_W-1:0]       drop_q;
	logic                   conf_q;
	logic [MID_W-1:0]       mid_q;
	logic [CNT_W-1:0]       confirm_q;
	logic [RATE_W-1:0]      rnum_q;
	logic                   out_valid_q;
	logic [RATE_W-1:0]      beat_rate_q;
	logic [PEAK_W-1:0]      smooth_q;

	logic                   div_start;
	logic [DW-1:0]          div_a;
	logic [DW-1:0]          div_b;
	logic                   div_done;
	logic [DW-1:0]          div_quo;

	logic [PROD_W-1:0]      smooth_prod;
	logic [PEAK_W-1:0]      smooth_val;
	logic [PEAK_W-1:0]      mid_ext;
	logic                   new_peak;
	logic                   is_low;
	logic [CNT_W-1:0]       drop_inc;
	logic                   beat;

	assign div_start = cmd.start_rate;
	assign div_a = DW'(rnum_q);
	assign div_b = DW'(pos_q);

	prpd_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign smooth_prod = PROD_W'(sum_q) * PROD_W'(RCP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smooth_q <= '0;
		end else if (cmd.start_smooth) begin
			smooth_q <= PEAK_W'(smooth_prod[PROD_W-1:RCP_SH]);
		end
	end

	assign smooth_val = smooth_q;
	assign mid_ext = PEAK_W'(mid_q);
	assign new_peak = smooth_val > peak_q;
	assign is_low = smooth_val < mid_ext;
	assign drop_inc = (drop_q == {CNT_W{1'b1}}) ? drop_q : drop_q + 1'b1;
	assign beat = !new_peak && is_low && !conf_q && (drop_inc >= confirm_q);

	assign sts.div_done = div_done;
	assign sts.beat = beat;
	assign sts.out_free = !out_valid_q || beat_rate_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q <= MID_LEVEL_RST;
			confirm_q <= CONFIRM_COUNT_RST;
			rnum_q <= RATE_NUMERATOR_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MID_LEVEL:      mid_q <= cfg_data[MID_W-1:0];
				CFG_CONFIRM_COUNT:  confirm_q <= cfg_data[CNT_W-1:0];
				CFG_RATE_NUMERATOR: rnum_q <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < FILTER_TAPS; i++) begin
				ring_q[i] <= '0;
			end
			ptr_q <= '0;
			sum_q <= '0;
		end else if (cmd.load) begin
			ring_q[ptr_q] <= sample;
			sum_q <= sum_q - SUM_W'(ring_q[ptr_q]) + SUM_W'(sample);
			ptr_q <= (ptr_q == TAP_W'(FILTER_TAPS - 1)) ? '0 : ptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			peak_q <= '0;
			pos_q <= '0;
			drop_q <= '0;
			conf_q <= 1'b0;
		end else if (cmd.load) begin
			elapsed_q <= elapsed_q + 1'b1;
		end else if (cmd.eval) begin
			if (new_peak) begin
				peak_q <= smooth_val;
				pos_q <= elapsed_q;
				conf_q <= 1'b0;
				drop_q <= '0;
			end else if (is_low) begin
				if (beat) begin
					elapsed_q <= elapsed_q - pos_q;
					peak_q <= mid_ext;
					conf_q <= 1'b1;
					drop_q <= '0;
				end else begin
					drop_q <= drop_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (beat_rate_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			beat_rate_q <= div_quo[RATE_W-1:0];
		end
	end

	assign beat_rate_valid = out_valid_q;
	assign beat_rate = beat_rate_q;

endmodule

`default_nettype wire

@@ sv/pulse_rate_peak_detector.sv @@
// Top level of the pulse rate peak detector: controller plus datapath.
// Depends on prpd_pkg, prpd_ctrl, prpd_datapath and prpd_div.
`default_nettype none

// Takes one raw sensor sample per transfer, smooths it over the last FILTER_TAPS
// samples and tracks the peak; on a confirmed peak it emits one beat_rate transfer.
// The division by the tap count is a reciprocal multiply; the beat rate uses a
// restoring divider, one bit per cycle over 16 bits. A sample that confirms no beat
// passes through transfer, smooth and evaluate; one that confirms a beat then
// waits for the rate division and the hand-off to the output register, plus any
// wait for the previous result to be taken. Input stalls on a held result only
// when a new beat is ready before that result leaves. Configuration writes take
// effect at once and are meant for an idle block.

module pulse_rate_peak_detector #(
	parameter int FILTER_TAPS = 10,
	parameter int SAMPLE_BITS = 12
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            sample_valid,
	output logic                                 sample_ready,
	input  wire logic [SAMPLE_BITS-1:0]          sample,
	output logic                                 beat_rate_valid,
	input  wire logic                            beat_rate_ready,
	output logic [prpd_pkg::RATE_W-1:0]          beat_rate,
	input  wire logic                            cfg_we,
	input  wire logic [prpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [prpd_pkg::CFG_DATA_W-1:0] cfg_data
);

	import prpd_pkg::*;

	prpd_cmd_t cmd;
	prpd_sts_t sts;

	prpd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	prpd_datapath #(
		.FILTER_TAPS (FILTER_TAPS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.sample          (sample),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.beat_rate_valid (beat_rate_valid),
		.beat_rate_ready (beat_rate_ready),
		.beat_rate       (beat_rate)
	);

endmodule

`default_nettype wire

@@ sv/prpd_checker.sv @@
// Port-level checks for pulse_rate_peak_detector, with the bind that attaches them.
// Depends on prpd_pkg for port widths.
`default_nettype none

module prpd_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        sample_valid,
	input wire logic                        sample_ready,
	input wire logic                        beat_rate_valid,
	input wire logic                        beat_rate_ready,
	input wire logic [prpd_pkg::RATE_W-1:0] beat_rate,
	input wire logic                        cfg_we
);

	logic in_xfer;

	assign in_xfer = sample_valid && sample_ready;

	// held result stays put until transferred
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		beat_rate_valid && !beat_rate_ready |=> beat_rate_valid && $stable(beat_rate))
		else $error("beat_rate dropped or changed while stalled");

	// one sample at a time: sample_ready stays low through the smoothing and evaluation that follow a transfer
	a_in_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !sample_ready ##1 !sample_ready)
		else $error("sample accepted while previous one still in work");

	// a new result only appears at the end of a sample's processing
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(beat_rate_valid) |-> !$past(sample_ready))
		else $error("beat_rate appeared while block was idle");

	// a result cannot appear in the cycle right after a sample transfer
	a_no_instant_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !beat_rate_valid && !cfg_we |=> !beat_rate_valid)
		else $error("beat_rate appeared without any processing time");

endmodule

bind pulse_rate_peak_detector prpd_checker u_prpd_checker (.*);

`default_nettype wire
